// File: sv/e2b_pkg.sv
// ----------------------------------------------------------------------------
// e2b_pkg
// Shared constants and types for the Euler angle to basis vector pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package e2b_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // 2*pi in Q30, used to turn a quarter-turn fraction into radians
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

    localparam int N_TERMS = 5;

    // Taylor term divisors (n+1)(n+2) and floor(2^30 / d) reciprocals
    localparam logic [6:0] SIN_DIV [N_TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
    localparam logic [6:0] COS_DIV [N_TERMS] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};

    localparam logic [29:0] SIN_RCP [N_TERMS] = '{
        30'(64'd1073741824 / 64'd6),
        30'(64'd1073741824 / 64'd20),
        30'(64'd1073741824 / 64'd42),
        30'(64'd1073741824 / 64'd72),
        30'(64'd1073741824 / 64'd110)
    };
    localparam logic [29:0] COS_RCP [N_TERMS] = '{
        30'(64'd1073741824 / 64'd2),
        30'(64'd1073741824 / 64'd12),
        30'(64'd1073741824 / 64'd30),
        30'(64'd1073741824 / 64'd56),
        30'(64'd1073741824 / 64'd90)
    };

    // stage counts of the two pipeline sections
    localparam int SC_LAT  = 5 + 3 * N_TERMS;
    localparam int BS_LAT  = 9;
    localparam int LATENCY = SC_LAT + BS_LAT;

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sincos_t;

endpackage

`default_nettype wire

// File: sv/e2b_sincos.sv
// ----------------------------------------------------------------------------
// e2b_sincos
// Pipelined sine and cosine of a binary angle: octant fold, radian scale,
// six-term Taylor series with reciprocal division, quadrant mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module e2b_sincos
    import e2b_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output sincos_t                    sc
);

    typedef struct packed {
        logic [29:0] x2;
        q30_t        sn;
        q30_t        cs;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [29:0] ps;
        logic [29:0] pc;
        logic [1:0]  quad;
        logic        mirror;
    } ser_t;

    // fold
    logic [29:0] r_a;
    logic [30:0] t_full;
    logic        mirror_a;
    logic [29:0] t_a_reg;
    logic [1:0]  quad_a_reg;
    logic        mirror_a_reg;

    assign r_a      = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    assign mirror_a = r_a > 30'h2000_0000;
    assign t_full   = 31'h4000_0000 - {1'b0, r_a};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_a_reg      <= mirror_a ? t_full[29:0] : r_a;
            quad_a_reg   <= angle[ANGLE_BITS-1 -: 2];
            mirror_a_reg <= mirror_a;
        end
    end

    // radians in Q30
    logic [62:0] xprod;
    logic [29:0] x_b_reg;
    logic [1:0]  quad_b_reg;
    logic        mirror_b_reg;

    assign xprod = {33'b0, t_a_reg} * {30'b0, TWO_PI_Q30};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_b_reg      <= xprod[61:32];
            quad_b_reg   <= quad_a_reg;
            mirror_b_reg <= mirror_a_reg;
        end
    end

    // x squared
    logic [59:0] xsq;
    logic [29:0] x_c_reg;
    logic [29:0] x2_c_reg;
    logic [1:0]  quad_c_reg;
    logic        mirror_c_reg;

    assign xsq = {30'b0, x_b_reg} * {30'b0, x_b_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_c_reg      <= x_b_reg;
            x2_c_reg     <= xsq[59:30];
            quad_c_reg   <= quad_b_reg;
            mirror_c_reg <= mirror_b_reg;
        end
    end

    // series: three stages per term
    ser_t step_in [N_TERMS];
    ser_t s1_reg  [N_TERMS];
    ser_t s2_reg  [N_TERMS];
    ser_t s3_reg  [N_TERMS];

    genvar j;
    generate
        for (j = 0; j < N_TERMS; j++)
        begin : g_term
            ser_t        s1_next;
            ser_t        s2_next;
            ser_t        s3_next;
            logic [60:0] sprod;
            logic [60:0] cprod;
            logic [59:0] sq;
            logic [59:0] cq;
            logic [37:0] schk;
            logic [37:0] cchk;

            if (j == 0)
            begin : g_first
                always_comb
                begin
                    step_in[j]        = '0;
                    step_in[j].x2     = x2_c_reg;
                    step_in[j].sn     = q30_t'({2'b0, x_c_reg});
                    step_in[j].cs     = q30_t'(32'h4000_0000);
                    step_in[j].ts     = {1'b0, x_c_reg};
                    step_in[j].tc     = 31'h4000_0000;
                    step_in[j].quad   = quad_c_reg;
                    step_in[j].mirror = mirror_c_reg;
                end
            end
            else
            begin : g_next
                assign step_in[j] = s3_reg[j-1];
            end

            assign sprod = {30'b0, step_in[j].ts} * {31'b0, step_in[j].x2};
            assign cprod = {30'b0, step_in[j].tc} * {31'b0, step_in[j].x2};

            // fold in the term finished by the previous step
            always_comb
            begin
                s1_next    = step_in[j];
                s1_next.ps = sprod[59:30];
                s1_next.pc = cprod[59:30];
                if (j > 0)
                begin
                    if ((j % 2) == 1)
                    begin
                        s1_next.sn = step_in[j].sn - q30_t'({1'b0, step_in[j].ts});
                        s1_next.cs = step_in[j].cs - q30_t'({1'b0, step_in[j].tc});
                    end
                    else
                    begin
                        s1_next.sn = step_in[j].sn + q30_t'({1'b0, step_in[j].ts});
                        s1_next.cs = step_in[j].cs + q30_t'({1'b0, step_in[j].tc});
                    end
                end
            end

            assign sq = {30'b0, s1_reg[j].ps} * {30'b0, SIN_RCP[j]};
            assign cq = {30'b0, s1_reg[j].pc} * {30'b0, COS_RCP[j]};

            // quotient estimate, at most one low
            always_comb
            begin
                s2_next    = s1_reg[j];
                s2_next.ts = {1'b0, sq[59:30]};
                s2_next.tc = {1'b0, cq[59:30]};
            end

            assign schk = ({8'b0, s2_reg[j].ts[29:0]} + 38'd1) * {31'b0, SIN_DIV[j]};
            assign cchk = ({8'b0, s2_reg[j].tc[29:0]} + 38'd1) * {31'b0, COS_DIV[j]};

            // correct the estimate
            always_comb
            begin
                s3_next    = s2_reg[j];
                s3_next.ts = {1'b0, s2_reg[j].ts[29:0]}
                           + 31'(schk <= {8'b0, s2_reg[j].ps});
                s3_next.tc = {1'b0, s2_reg[j].tc[29:0]}
                           + 31'(cchk <= {8'b0, s2_reg[j].pc});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s1_reg[j] <= s1_next;
                    s2_reg[j] <= s2_next;
                    s3_reg[j] <= s3_next;
                end
            end
        end
    endgenerate

    // last term (odd step, subtract)
    q30_t       sn_f_reg;
    q30_t       cs_f_reg;
    logic [1:0] quad_f_reg;
    logic       mirror_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_f_reg     <= s3_reg[N_TERMS-1].sn - q30_t'({1'b0, s3_reg[N_TERMS-1].ts});
            cs_f_reg     <= s3_reg[N_TERMS-1].cs - q30_t'({1'b0, s3_reg[N_TERMS-1].tc});
            quad_f_reg   <= s3_reg[N_TERMS-1].quad;
            mirror_f_reg <= s3_reg[N_TERMS-1].mirror;
        end
    end

    // quadrant mapping
    q30_t    s0;
    q30_t    c0;
    sincos_t sc_next;
    sincos_t sc_reg;

    assign s0 = mirror_f_reg ? cs_f_reg : sn_f_reg;
    assign c0 = mirror_f_reg ? sn_f_reg : cs_f_reg;

    always_comb
    begin
        case (quad_f_reg)
            2'd0:    begin sc_next.s = s0;  sc_next.c = c0;  end
            2'd1:    begin sc_next.s = c0;  sc_next.c = -s0; end
            2'd2:    begin sc_next.s = -s0; sc_next.c = -c0; end
            default: begin sc_next.s = -c0; sc_next.c = s0;  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

`default_nettype wire

// File: sv/e2b_basis.sv
// ----------------------------------------------------------------------------
// e2b_basis
// Forms forward, right and up vectors from the three sine/cosine pairs with
// rounded Q30 products, then rounds and saturates to the output format.
// ----------------------------------------------------------------------------
`default_nettype none

module e2b_basis
    import e2b_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire sincos_t                 pitch,
    input  wire sincos_t                 yaw,
    input  wire sincos_t                 roll,
    output logic [8:0][FRAC_BITS+1:0]    vec
);

    localparam int OUT_W = FRAC_BITS + 2;
    localparam int SH    = 30 - FRAC_BITS;

    localparam int SP = 0;
    localparam int CP = 1;
    localparam int SY = 2;
    localparam int CY = 3;
    localparam int SR = 4;
    localparam int CR = 5;

    localparam int SRSP = 0;
    localparam int CRSP = 1;
    localparam int CPCY = 2;
    localparam int CPSY = 3;
    localparam int CRSY = 4;
    localparam int CRCY = 5;
    localparam int SRCP = 6;
    localparam int CRCP = 7;
    localparam int SRSY = 8;
    localparam int SRCY = 9;

    localparam int PA [10] = '{SR, CR, CP, CP, CR, CR, SR, CR, SR, SR};
    localparam int PB [10] = '{SP, SP, CY, SY, SY, CY, CP, CP, SY, CY};

    // second-level products: srsp*cy, srsp*sy, crsp*cy, crsp*sy
    localparam int QA [4] = '{SRSP, SRSP, CRSP, CRSP};
    localparam int QB [4] = '{CY, SY, CY, SY};

    q30_t v_in [6];

    assign v_in[SP] = pitch.s;
    assign v_in[CP] = pitch.c;
    assign v_in[SY] = yaw.s;
    assign v_in[CY] = yaw.c;
    assign v_in[SR] = roll.s;
    assign v_in[CR] = roll.c;

    // B1: sign and magnitude
    logic [30:0] mag1_reg [6];
    logic        sgn1_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mag1_reg[i] <= v_in[i][31] ? 31'(-v_in[i]) : 31'(v_in[i]);
                sgn1_reg[i] <= v_in[i][31];
            end
        end
    end

    // B2: first products
    logic [61:0] p2_reg   [10];
    logic        ps2_reg  [10];
    logic [30:0] mag2_reg [6];
    logic        sgn2_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 10; i++)
            begin
                p2_reg[i]  <= {31'b0, mag1_reg[PA[i]]} * {31'b0, mag1_reg[PB[i]]};
                ps2_reg[i] <= sgn1_reg[PA[i]] ^ sgn1_reg[PB[i]];
            end
            for (int i = 0; i < 6; i++)
            begin
                mag2_reg[i] <= mag1_reg[i];
                sgn2_reg[i] <= sgn1_reg[i];
            end
        end
    end

    // B3: round to Q30, half away from zero
    logic [62:0] rnd3     [10];
    logic [30:0] m3_reg   [10];
    logic        s3_reg   [10];
    logic [30:0] mag3_reg [6];
    logic        sgn3_reg [6];

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            rnd3[i] = {1'b0, p2_reg[i]} + 63'h2000_0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 10; i++)
            begin
                m3_reg[i] <= rnd3[i][60:30];
                s3_reg[i] <= ps2_reg[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                mag3_reg[i] <= mag2_reg[i];
                sgn3_reg[i] <= sgn2_reg[i];
            end
        end
    end

    // B4: second products, signed first products
    logic [61:0] p4_reg  [4];
    logic        ps4_reg [4];
    q30_t        f4_reg  [10];
    q30_t        sp4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                p4_reg[i]  <= {31'b0, m3_reg[QA[i]]} * {31'b0, mag3_reg[QB[i]]};
                ps4_reg[i] <= s3_reg[QA[i]] ^ sgn3_reg[QB[i]];
            end
            for (int i = 0; i < 10; i++)
            begin
                f4_reg[i] <= s3_reg[i] ? -q30_t'({1'b0, m3_reg[i]})
                                       :  q30_t'({1'b0, m3_reg[i]});
            end
            sp4_reg <= sgn3_reg[SP] ? -q30_t'({1'b0, mag3_reg[SP]})
                                    :  q30_t'({1'b0, mag3_reg[SP]});
        end
    end

    // B5: round second products
    logic [62:0] rnd5   [4];
    q30_t        q5_reg [4];
    q30_t        f5_reg [10];
    q30_t        sp5_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rnd5[i] = {1'b0, p4_reg[i]} + 63'h2000_0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                q5_reg[i] <= ps4_reg[i] ? -q30_t'({1'b0, rnd5[i][60:30]})
                                        :  q30_t'({1'b0, rnd5[i][60:30]});
            end
            for (int i = 0; i < 10; i++)
            begin
                f5_reg[i] <= f4_reg[i];
            end
            sp5_reg <= sp4_reg;
        end
    end

    // B6: vector components
    logic signed [33:0] v6_next [9];
    logic signed [33:0] v6_reg  [9];

    always_comb
    begin
        v6_next[0] = 34'(f5_reg[CPCY]);
        v6_next[1] = 34'(f5_reg[CPSY]);
        v6_next[2] = -34'(sp5_reg);
        v6_next[3] = 34'(f5_reg[CRSY]) - 34'(q5_reg[0]);
        v6_next[4] = -34'(q5_reg[1]) - 34'(f5_reg[CRCY]);
        v6_next[5] = -34'(f5_reg[SRCP]);
        v6_next[6] = 34'(q5_reg[2]) + 34'(f5_reg[SRSY]);
        v6_next[7] = 34'(q5_reg[3]) - 34'(f5_reg[SRCY]);
        v6_next[8] = 34'(f5_reg[CRCP]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                v6_reg[i] <= v6_next[i];
            end
        end
    end

    // B7: sign and magnitude
    logic [33:0] m7_reg [9];
    logic        s7_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m7_reg[i] <= v6_reg[i][33] ? 34'(-v6_reg[i]) : 34'(v6_reg[i]);
                s7_reg[i] <= v6_reg[i][33];
            end
        end
    end

    // B8: round to output fraction bits
    logic [33:0] m8_next [9];
    logic [33:0] m8_reg  [9];
    logic        s8_reg  [9];

    generate
        if (SH > 0)
        begin : g_round
            always_comb
            begin
                for (int i = 0; i < 9; i++)
                begin
                    m8_next[i] = (m7_reg[i] + (34'd1 << (SH - 1))) >> SH;
                end
            end
        end
        else
        begin : g_noround
            always_comb
            begin
                for (int i = 0; i < 9; i++)
                begin
                    m8_next[i] = m7_reg[i];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m8_reg[i] <= m8_next[i];
                s8_reg[i] <= s7_reg[i];
            end
        end
    end

    // B9: saturate and apply sign
    logic [33:0]       one_out;
    logic [OUT_W-1:0]  sat9 [9];
    logic [8:0][OUT_W-1:0] vec_reg;

    assign one_out = 34'd1 << FRAC_BITS;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            sat9[i] = (m8_reg[i] > one_out) ? OUT_W'(one_out) : OUT_W'(m8_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                vec_reg[i] <= s8_reg[i] ? -sat9[i] : sat9[i];
            end
        end
    end

    assign vec = vec_reg;

endmodule

`default_nettype wire

// File: sv/euler_angles_to_basis_vectors_top.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_top
// Pitch, yaw and roll binary angles in; forward, right and up vectors out.
// The pipeline has 20 sine/cosine stages and 9 vector stages.
// Throughput: one request per cycle; a stalled output freezes the pipeline.
// Reset clears all valid bits; no request is in flight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angles_to_basis_vectors_top
    import e2b_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W      = ((3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = FRAC_BITS + 2,
    localparam int OUT_DW    = ((9 * OUT_W + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // pitch_angle, yaw_angle, roll_angle
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // forward_x, forward_y, forward_z, right_x, right_y, right_z, up_x, up_y, up_z
    output logic [OUT_DW-1:0]      m_tdata
);

    logic                    en;
    logic [LATENCY-1:0]      vld_reg;
    logic [LATENCY-1:0]      vld_next;
    sincos_t                 sc_pitch;
    sincos_t                 sc_yaw;
    sincos_t                 sc_roll;
    logic [8:0][OUT_W-1:0]   vec;

    // advance everything whenever the output register is free or drained
    assign en       = ~vld_reg[LATENCY-1] | m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LATENCY-1];
    assign vld_next = {vld_reg[LATENCY-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    e2b_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_pitch
    (
        .clk   (clk),
        .en    (en),
        .angle (s_tdata[ANGLE_BITS-1:0]),
        .sc    (sc_pitch)
    );

    e2b_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_yaw
    (
        .clk   (clk),
        .en    (en),
        .angle (s_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .sc    (sc_yaw)
    );

    e2b_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_roll
    (
        .clk   (clk),
        .en    (en),
        .angle (s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
        .sc    (sc_roll)
    );

    e2b_basis #(.FRAC_BITS(FRAC_BITS)) u_basis
    (
        .clk   (clk),
        .en    (en),
        .pitch (sc_pitch),
        .yaw   (sc_yaw),
        .roll  (sc_roll),
        .vec   (vec)
    );

    assign m_tdata = OUT_DW'(vec);

endmodule

`default_nettype wire
